FILE: rtl/sglu_pkg.sv
// Shared constants and controller/datapath interface types for the gcd/lcm unit.
`timescale 1ns / 1ps

package sglu_pkg;

  localparam int unsigned OPND_W         = 64;
  localparam int unsigned DATA_WIDTH_DEF = 64;
  localparam int unsigned TDATA_IN_W     = 2 * OPND_W;

  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an input word
    logic gcd_step;  // one binary gcd step
    logic gcd_fin;   // form gcd, start divider
    logic div_step;  // one quotient bit
    logic mul_init;  // load multiplier
    logic mul_step;  // one shift-add
    logic out_load;  // move result into output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gcd_done;  // one of the gcd registers reached zero
    logic use_mul;   // lcm with both operands nonzero
    logic cnt_zero;  // last divide or multiply step
    logic out_free;  // output register can take a word
  } sts_t;

endpackage

FILE: rtl/sglu_ctrl.sv
// Controller state machine sequencing gcd, divide and multiply phases.
`timescale 1ns / 1ps

module sglu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sglu_pkg::sts_t sts_i,
  output sglu_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MULI,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.gcd_fin = 1'b1;
          state_d       = sts_i.use_mul ? ST_DIV : ST_FIN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) state_d = ST_MULI;
      end
      ST_MULI: begin
        cmd_o.mul_init = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_zero) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One word in flight: no accept right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sglu_ctrl: accepted two words back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("sglu_ctrl: result loaded over a pending word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.gcd_step, cmd_o.gcd_fin, cmd_o.div_step,
              cmd_o.mul_init, cmd_o.mul_step, cmd_o.out_load}))
    else $error("sglu_ctrl: conflicting datapath commands");

endmodule

FILE: rtl/sglu_datapath.sv
// Datapath: binary gcd, restoring divider, shift-add multiplier, output register.
`timescale 1ns / 1ps

module sglu_datapath #(
  parameter int unsigned DATA_WIDTH = sglu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sglu_pkg::cmd_t        cmd_i,
  output sglu_pkg::sts_t        sts_o,
  input  logic                  in_opcode_i,
  input  logic [DATA_WIDTH-1:0] in_a_i,
  input  logic [DATA_WIDTH-1:0] in_b_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [DATA_WIDTH-1:0] out_answer_o,
  output logic                  out_overflow_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0]  MinMag  = {1'b1, {(W-1){1'b0}}};
  localparam logic [CW-1:0] CntLast = CW'(W - 1);

  logic [W-1:0]    x_q, x_d, y_q, y_d, g_q;
  logic [CW-1:0]   k_q, k_d, cnt_q;
  logic [W-1:0]    ma_q, mb_q;
  logic            neg_a_q, neg_b_q, lcm_q, zero_q;
  logic [W-1:0]    rem_q, quo_q;
  logic [2*W-1:0]  acc_q, mcand_q;
  logic [W-1:0]    mplier_q;
  logic [W-1:0]    ans_q, ans_d;
  logic            ovf_q, ovf_d, out_vld_q;

  // Operand magnitudes; the most negative value maps to 2^(W-1).
  logic a_neg, b_neg;
  logic [W-1:0] a_mag, b_mag;
  assign a_neg = in_a_i[W-1];
  assign b_neg = in_b_i[W-1];
  assign a_mag = a_neg ? (~in_a_i + W'(1)) : in_a_i;
  assign b_mag = b_neg ? (~in_b_i + W'(1)) : in_b_i;

  // Binary gcd step.
  logic [W-1:0] diff_xy, diff_yx;
  assign diff_xy = x_q - y_q;
  assign diff_yx = y_q - x_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    if (!x_q[0] && !y_q[0]) begin
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + CW'(1);
    end else if (!x_q[0]) begin
      x_d = x_q >> 1;
    end else if (!y_q[0]) begin
      y_d = y_q >> 1;
    end else if (x_q >= y_q) begin
      x_d = diff_xy >> 1;
    end else begin
      y_d = diff_yx >> 1;
    end
  end

  logic [W-1:0] g_fin;
  assign g_fin = (x_q | y_q) << k_q;

  // Restoring divider, one quotient bit per cycle.
  logic [W:0] rem_sh, rem_sub;
  logic       rem_ge;
  assign rem_sh  = {rem_q, quo_q[W-1]};
  assign rem_ge  = rem_sh >= {1'b0, g_q};
  assign rem_sub = rem_sh - {1'b0, g_q};

  // Result forming.
  logic         g_is_min, neg_p;
  logic [W-1:0] p_lo, p_w, lcm_ans;
  logic         lcm_ovf;
  assign g_is_min = (g_q == MinMag);
  assign neg_p    = neg_a_q ^ g_is_min ^ neg_b_q;
  assign p_lo     = acc_q[W-1:0];
  assign p_w      = neg_p ? (~p_lo + W'(1)) : p_lo;
  assign lcm_ans  = p_w[W-1] ? (~p_w + W'(1)) : p_w;
  // Magnitude at or past 2^(W-1), or a gcd of 2^(W-1), overflows.
  assign lcm_ovf  = g_is_min || (acc_q[2*W-1:W-1] != '0);

  always_comb begin
    if (!lcm_q) begin
      ans_d = g_q;
      ovf_d = g_is_min;
    end else if (zero_q) begin
      ans_d = '0;
      ovf_d = 1'b0;
    end else begin
      ans_d = lcm_ans;
      ovf_d = lcm_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= a_mag;
      y_q     <= b_mag;
      k_q     <= '0;
      ma_q    <= a_mag;
      mb_q    <= b_mag;
      neg_a_q <= a_neg;
      neg_b_q <= b_neg;
      lcm_q   <= (in_opcode_i == sglu_pkg::OP_LCM);
      zero_q  <= (in_a_i == '0) || (in_b_i == '0);
    end
    if (cmd_i.gcd_step) begin
      x_q <= x_d;
      y_q <= y_d;
      k_q <= k_d;
    end
    if (cmd_i.gcd_fin) begin
      g_q   <= g_fin;
      rem_q <= '0;
      quo_q <= ma_q;
      cnt_q <= CntLast;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], rem_ge};
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.mul_init) begin
      acc_q    <= '0;
      mcand_q  <= {{W{1'b0}}, quo_q};
      mplier_q <= mb_q;
      cnt_q    <= CntLast;
    end
    if (cmd_i.mul_step) begin
      acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      cnt_q    <= cnt_q - CW'(1);
    end
    if (cmd_i.out_load) begin
      ans_q <= ans_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.gcd_done = (x_q == '0) || (y_q == '0);
  assign sts_o.use_mul  = lcm_q && !zero_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o    = out_vld_q;
  assign out_answer_o   = ans_q;
  assign out_overflow_o = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> ((x_q != '0) && (y_q != '0)))
    else $error("sglu_datapath: gcd step with a zero operand");

  // The left shift by the common power of two never drops bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.gcd_fin && ((x_q | y_q) != '0)) |=> (g_q != '0))
    else $error("sglu_datapath: gcd lost its value in the final shift");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !lcm_q) |=> (ovf_q == (ans_q == MinMag)))
    else $error("sglu_datapath: gcd overflow flag mismatch");

endmodule

FILE: rtl/signed_gcd_lcm_unit.sv
// Top level: stream ports around the gcd/lcm controller and datapath.
`timescale 1ns / 1ps

// Signed gcd / lcm unit.
// Slave stream: one word per item, tdata = {operand_b, operand_a}, tuser = opcode
// (0 gcd, 1 lcm). Only the low DATA_WIDTH bits of each operand are used.
// Master stream: tdata = answer sign-extended to 64 bits, tuser = overflow.
// One item at a time. The gcd runs a binary (subtract-and-shift) loop, one step
// per cycle, at most 2*DATA_WIDTH-1 steps; the lcm then adds a restoring
// divide of |a| by the gcd and a shift-add multiply by |b| on the same datapath.
// Operands with a zero skip the gcd loop. A new word can be accepted in the cycle
// after the previous result is moved to the output register.
// The output register holds its word while m_axis_tready is low; the next
// item is still accepted and computed, and waits in its final state.
// Reset clears the controller and the output valid; no item is made up.
module signed_gcd_lcm_unit #(
  parameter int unsigned DATA_WIDTH = sglu_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sglu_pkg::TDATA_IN_W-1:0] s_axis_tdata,  // operand_a, operand_b
  input  logic                            s_axis_tuser,  // opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sglu_pkg::OPND_W-1:0]     m_axis_tdata,  // answer
  output logic                            m_axis_tuser   // overflow
);

  localparam int unsigned OW = sglu_pkg::OPND_W;

  sglu_pkg::cmd_t cmd;
  sglu_pkg::sts_t sts;

  logic [DATA_WIDTH-1:0]        op_a, op_b, ans;
  logic signed [DATA_WIDTH-1:0] ans_s;

  assign op_a = s_axis_tdata[DATA_WIDTH-1:0];
  assign op_b = s_axis_tdata[OW+DATA_WIDTH-1:OW];

  sglu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sglu_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_opcode_i    (s_axis_tuser),
    .in_a_i         (op_a),
    .in_b_i         (op_b),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_answer_o   (ans),
    .out_overflow_o (m_axis_tuser)
  );

  assign ans_s        = ans;
  assign m_axis_tdata = OW'(ans_s);

endmodule
